>>> hdl/wled_pkg.sv
// Shared constants, types and the queue entry for the local extrema detector.
package wled_pkg;

  localparam int MAX_SPAN    = 16;
  localparam int SAMPLE_BITS = 16;
  localparam int INDEX_BITS  = 32;
  localparam int SPAN_W      = 5;
  localparam int WIN_DEPTH   = 2 * MAX_SPAN + 1;
  localparam int WIN_IDX_W   = $clog2(WIN_DEPTH);
  localparam int QDEPTH      = 2;
  localparam int QPTR_W      = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int APB_ADDR_W  = 3;
  localparam int APB_DATA_W  = 32;
  localparam int REG_IDX_W   = APB_ADDR_W - 2;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [INDEX_BITS-1:0]         index_t;
  typedef logic [SPAN_W-1:0]             span_t;
  typedef logic [REG_IDX_W-1:0]          reg_idx_t;

  localparam span_t    SPAN_RESET = span_t'(4);
  localparam reg_idx_t REG_SPAN   = reg_idx_t'(0);

  typedef struct packed {
    logic    sos;
    logic    eligible;
    logic    is_min;
    logic    is_max;
    index_t  position;
    sample_t value;
  } cls_t;

endpackage

>>> hdl/wled_in_if.sv
// Input stream channel: one sample word with its start-of-set flag.
interface wled_in_if
  import wled_pkg::*;
();
  logic    valid;
  logic    ready;
  sample_t sample;
  logic    start_of_set;

  modport source (output valid, sample, start_of_set, input ready);
  modport sink   (input valid, sample, start_of_set, output ready);
endinterface

>>> hdl/wled_out_if.sv
// Result stream channel: one extremum word per handshake.
interface wled_out_if
  import wled_pkg::*;
();
  logic    valid;
  logic    ready;
  index_t  position;
  logic    is_maximum;
  sample_t value;

  modport source (output valid, position, is_maximum, value, input ready);
  modport sink   (input valid, position, is_maximum, value, output ready);
endinterface

>>> hdl/wled_front.sv
// Front end: sample window, position count and per-word extremum classification.
module wled_front
  import wled_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  span_t span_i,
  wled_in_if.sink in_i,
  input  logic  full_i,
  output logic  push_o,
  output cls_t  entry_o
);

  sample_t win_q [WIN_DEPTH];
  sample_t win_d [WIN_DEPTH];
  index_t  cnt_q, cnt_d;
  index_t  base;
  span_t   sp;
  logic [WIN_IDX_W-1:0] span2;
  logic    sat;
  logic    accept;
  sample_t centre;
  logic    is_min, is_max;

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && in_i.ready;
  assign push_o     = accept;

  always_comb begin
    if (span_i == '0) begin
      sp = span_t'(1);
    end else if (span_i > span_t'(MAX_SPAN)) begin
      sp = span_t'(MAX_SPAN);
    end else begin
      sp = span_i;
    end
    span2 = {sp, 1'b0};
  end

  always_comb begin
    win_d[0] = in_i.sample;
    for (int i = 1; i < WIN_DEPTH; i++) begin
      win_d[i] = in_i.start_of_set ? sample_t'(0) : win_q[i-1];
    end
    base  = in_i.start_of_set ? '0 : cnt_q;
    sat   = &base;
    cnt_d = sat ? base : base + index_t'(1);
  end

  always_comb begin
    centre = win_d[WIN_IDX_W'(sp)];
    is_min = 1'b1;
    is_max = 1'b1;
    for (int i = 0; i < WIN_DEPTH; i++) begin
      if ((WIN_IDX_W'(i) <= span2) && (WIN_IDX_W'(i) != WIN_IDX_W'(sp))) begin
        if (centre > win_d[i]) begin
          is_min = 1'b0;
        end
        if (centre < win_d[i]) begin
          is_max = 1'b0;
        end
      end
    end
  end

  always_comb begin
    entry_o.sos      = in_i.start_of_set;
    entry_o.eligible = !sat && (base > index_t'(span2));
    entry_o.is_min   = is_min;
    entry_o.is_max   = is_max;
    entry_o.position = base - index_t'(sp);
    entry_o.value    = centre;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      for (int i = 0; i < WIN_DEPTH; i++) begin
        win_q[i] <= '0;
      end
    end else if (accept) begin
      cnt_q <= cnt_d;
      for (int i = 0; i < WIN_DEPTH; i++) begin
        win_q[i] <= win_d[i];
      end
    end
  end

endmodule

>>> hdl/wled_queue.sv
// Short FIFO of classified words between the front and back ends.
module wled_queue
  import wled_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cls_t entry_i,
  output logic full_o,
  output logic valid_o,
  input  logic pop_i,
  output cls_t entry_o
);

  cls_t mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QPTR_W:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == (QPTR_W+1)'(QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign entry_o = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_q + QPTR_W'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_q + QPTR_W'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + (QPTR_W+1)'(1);
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - (QPTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("pop from empty queue");
`endif

endmodule

>>> hdl/wled_back.sv
// Back end: skip-next tracking and the registered result word.
module wled_back
  import wled_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  input  cls_t entry_i,
  output logic pop_o,
  wled_out_if.source out_o
);

  logic    skip_q, skip_d;
  logic    skip_eff;
  logic    emit;
  logic    stall;
  logic    out_valid_q;
  index_t  pos_q;
  logic    max_q;
  sample_t val_q;

  assign skip_eff = entry_i.sos ? 1'b0 : skip_q;
  assign emit     = entry_i.eligible && (entry_i.is_min || entry_i.is_max) && !skip_eff;
  assign stall    = emit && out_valid_q && !out_o.ready;
  assign pop_o    = valid_i && !stall;
  assign skip_d   = entry_i.eligible ? emit : skip_eff;

  assign out_o.valid      = out_valid_q;
  assign out_o.position   = pos_q;
  assign out_o.is_maximum = max_q;
  assign out_o.value      = val_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        skip_q <= skip_d;
      end
      if (pop_o && emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && emit) begin
      pos_q <= entry_i.position;
      max_q <= !entry_i.is_min;
      val_q <= entry_i.value;
    end
  end

`ifndef SYNTHESIS
  a_emit_sets_skip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && emit) |=> (skip_q && out_o.valid))
    else $error("emitted word did not arm skip");

  a_sos_not_eligible: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_i && entry_i.sos) |-> !entry_i.eligible)
    else $error("first word of a set tested as candidate");

  a_skip_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && skip_q && !entry_i.sos && entry_i.eligible) |=> !skip_q)
    else $error("skip not consumed by candidate");
`endif

endmodule

>>> hdl/windowed_local_extrema_detector_core.sv
// Windowed local extrema detector: accepts one sample word per clock while the
// queue is not full; the whole window of up to 33 samples is compared against its
// centre in the cycle a word is taken, the classified word passes through a
// two-entry queue, and a result word is loaded into the output register when the
// back end pops its entry from the queue. The output may stall independently; the
// input is held off only once the queue has filled.
module windowed_local_extrema_detector_core
  import wled_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  wled_in_if.sink               in_i,
  wled_out_if.source            out_o
);

  span_t    span_q;
  reg_idx_t reg_idx;
  logic     push, full, q_valid, pop;
  cls_t     q_in, q_out;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_ADDR_W-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      span_q <= SPAN_RESET;
    end else if (psel && penable && pwrite && (reg_idx == REG_SPAN)) begin
      span_q <= pwdata[SPAN_W-1:0];
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SPAN: prdata = APB_DATA_W'(span_q);
      default:  prdata = '0;
    endcase
  end

  wled_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .span_i  (span_q),
    .in_i    (in_i),
    .full_i  (full),
    .push_o  (push),
    .entry_o (q_in)
  );

  wled_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (q_in),
    .full_o  (full),
    .valid_o (q_valid),
    .pop_i   (pop),
    .entry_o (q_out)
  );

  wled_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_valid),
    .entry_i (q_out),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

>>> test/windowed_local_extrema_detector_core_tb.sv
// Self-checking bench for the windowed local extrema detector core.
`timescale 1ns / 1ps

module windowed_local_extrema_detector_core_tb;
  import wled_pkg::*;

  localparam int PHASES        = 9;
  localparam int PHASE_WORDS   = 80;
  localparam int SETTLE_CYCLES = 8;
  localparam int STALL_LIMIT   = 2000;

  typedef struct packed {
    sample_t sample;
    logic    start_of_set;
  } sample_word_t;

  typedef struct packed {
    index_t  position;
    logic    is_maximum;
    sample_t value;
  } extremum_t;

  typedef enum logic [1:0] {SHAPE_NOISE, SHAPE_WALK, SHAPE_TIES, SHAPE_PLATEAU} shape_e;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  wled_in_if  in_if ();
  wled_out_if out_if ();

  windowed_local_extrema_detector_core dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_i    (in_if),
    .out_o   (out_if)
  );

  sample_word_t samples_to_send[$];
  extremum_t    extremum_q[$];

  sample_t recent [WIN_DEPTH];
  index_t  next_index;
  logic    skip_pending;
  span_t   span_setting;

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned words_queued;
  int unsigned words_taken;
  int unsigned minima_seen;
  int unsigned maxima_seen;
  int unsigned mismatches;
  int unsigned quiet_cycles;

  function automatic int unsigned effective_span(input span_t v);
    if (v == '0) return 1;
    if (v > MAX_SPAN) return MAX_SPAN;
    return int'(v);
  endfunction

  function automatic logic predict_extremum(input sample_t s, input logic fresh,
                                            output extremum_t ext);
    int unsigned sp;
    index_t      k;
    sample_t     centre;
    logic        lowest;
    logic        highest;
    sp = effective_span(span_setting);
    ext = '0;
    if (fresh) begin
      foreach (recent[i]) recent[i] = '0;
      next_index   = '0;
      skip_pending = 1'b0;
    end
    for (int i = WIN_DEPTH - 1; i > 0; i--) recent[i] = recent[i-1];
    recent[0] = s;
    if (next_index == '1) return 1'b0;
    k = next_index;
    next_index++;
    if (k < 2 * sp + 1) return 1'b0;
    if (skip_pending) begin
      skip_pending = 1'b0;
      return 1'b0;
    end
    centre  = recent[sp];
    lowest  = 1'b1;
    highest = 1'b1;
    for (int j = 1; j <= sp; j++) begin
      if (centre > recent[sp-j] || centre > recent[sp+j]) lowest = 1'b0;
      if (centre < recent[sp-j] || centre < recent[sp+j]) highest = 1'b0;
    end
    if (!lowest && !highest) return 1'b0;
    skip_pending   = 1'b1;
    ext.position   = k - index_t'(sp);
    ext.is_maximum = !lowest;
    ext.value      = centre;
    return 1'b1;
  endfunction

  task automatic write_span(input span_t v);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'(4 * REG_SPAN);
    pwdata  <= APB_DATA_W'(v);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    span_setting = v;
  endtask

  task automatic push_word(input sample_t s, input logic fresh);
    sample_word_t w;
    w.sample       = s;
    w.start_of_set = fresh;
    samples_to_send = {samples_to_send, w};
    words_queued++;
  endtask

  task automatic queue_set(input int unsigned len, input logic fresh);
    shape_e  shape;
    int      level;
    sample_t base;
    shape = shape_e'($urandom_range(3));
    base  = sample_t'($urandom);
    level = int'(base);
    if (base > sample_t'(32765)) base = sample_t'(32765);
    for (int unsigned i = 0; i < len; i++) begin
      case (shape)
        SHAPE_NOISE: level = int'(sample_t'($urandom));
        SHAPE_WALK: begin
          level = level + int'($urandom_range(200)) - 100;
          if (level > 32767) level = 32767;
          if (level < -32768) level = -32768;
        end
        SHAPE_TIES: level = int'(base) + int'($urandom_range(2));
        default: if ($urandom_range(3) == 0) level = int'(sample_t'($urandom));
      endcase
      push_word(sample_t'(level), fresh && i == 0);
    end
  endtask

  task automatic wait_idle();
    while (words_taken != words_queued || extremum_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid        <= 1'b0;
      in_if.sample       <= '0;
      in_if.start_of_set <= 1'b0;
    end else if (!in_if.valid || in_if.ready) begin
      if (samples_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        sample_word_t w;
        w = samples_to_send.pop_front();
        in_if.valid        <= 1'b1;
        in_if.sample       <= w.sample;
        in_if.start_of_set <= w.start_of_set;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin : take_sample
    extremum_t ext;
    if (rst_ni && in_if.valid && in_if.ready) begin
      words_taken++;
      if (predict_extremum(in_if.sample, in_if.start_of_set, ext)) begin
        extremum_q = {extremum_q, ext};
      end
    end
  end

  always @(posedge clk_i) begin : check_extremum
    extremum_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (extremum_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected word: expected none, got position %0d is_maximum %0b value %0d",
                 $time, out_if.position, out_if.is_maximum, out_if.value);
      end else begin
        want = extremum_q.pop_front();
        if (out_if.is_maximum) maxima_seen++;
        else minima_seen++;
        if (out_if.position !== want.position) begin
          mismatches++;
          $display("%0t: position expected %0d got %0d", $time, want.position, out_if.position);
        end
        if (out_if.is_maximum !== want.is_maximum) begin
          mismatches++;
          $display("%0t: is_maximum expected %0b got %0b at position %0d", $time,
                   want.is_maximum, out_if.is_maximum, want.position);
        end
        if (out_if.value !== want.value) begin
          mismatches++;
          $display("%0t: value expected %0d got %0d at position %0d", $time,
                   want.value, out_if.value, want.position);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
        $display("windowed_local_extrema_detector_core verification failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    span_t       span_plan [PHASES];
    sample_t     opening [20];
    int unsigned sp;
    int unsigned len;
    int unsigned queued;
    span_plan = '{SPAN_RESET, 5'd1, 5'd16, 5'd0, 5'd31, 5'd17, 5'd2, 5'd8, 5'd5};
    opening   = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 32767, -5, -32768, -7, -3, 1, 2, 3, 4, 5};
    rst_ni             = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    send_idle_pct      = 24;
    recv_stall_pct     = 88;
    words_queued       = 0;
    foreach (recent[i]) recent[i] = '0;
    next_index   = '0;
    skip_pending = 1'b0;
    span_setting = SPAN_RESET;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int p = 0; p < PHASES; p++) begin
      if (p == 3) begin
        send_idle_pct  = 88;
        recv_stall_pct = 24;
      end else if (p == 6) begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      if (p != 0) write_span(span_plan[p]);
      sp = effective_span(span_setting);
      if (p == 0) begin
        foreach (opening[i]) push_word(opening[i], i == 0);
        push_word(sample_t'(-32768), 1'b1);
        push_word(sample_t'(32767), 1'b0);
        push_word(sample_t'(1), 1'b0);
        push_word(sample_t'(-1), 1'b1);
      end else begin
        queued = 0;
        while (queued < PHASE_WORDS) begin
          if ($urandom_range(9) == 0) len = $urandom_range(2 * sp, 1);
          else len = $urandom_range(2 * sp + 40, 2 * sp + 1);
          queue_set(len, !(queued == 0 && $urandom_range(1) == 0));
          queued += len;
        end
      end
      wait_idle();
    end

    $display("Sent %0d samples over %0d span settings (0, 1, 16, 17 and 31 among them).",
             words_taken, PHASES);
    $display("Checked %0d minima and %0d maxima under three idling patterns.",
             minima_seen, maxima_seen);
    if (mismatches == 0 && extremum_q.size() == 0) begin
      $display("windowed_local_extrema_detector_core verification clean");
    end else begin
      $display("windowed_local_extrema_detector_core verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/wled_pkg.sv
hdl/wled_in_if.sv
hdl/wled_out_if.sv
hdl/wled_front.sv
hdl/wled_queue.sv
hdl/wled_back.sv
hdl/windowed_local_extrema_detector_core.sv
test/windowed_local_extrema_detector_core_tb.sv
